// ===== design/wrapped_bilinear_texture_sampler_top_macros.svh =====
// Assertion macros for the texture sampler checker.
// Depends on nothing; included by the checker file.
`ifndef WRAPPED_BILINEAR_TEXTURE_SAMPLER_TOP_MACROS_SVH
`define WRAPPED_BILINEAR_TEXTURE_SAMPLER_TOP_MACROS_SVH

// Implication in the same cycle, disabled in reset.
`define WBTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("texture sampler check failed");

// Implication on the next cycle, disabled in reset.
`define WBTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("texture sampler check failed");

// Check that holds across reset itself.
`define WBTS_ASSERT_RST(lbl, clk, rst_n, cons) \
    lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error("texture sampler reset check failed");

`endif

// ===== design/wbts_pkg.sv =====
// Shared constants for the wrapped bilinear texture sampler.
// No dependencies; used by the interfaces and all modules but the RAM.
package wbts_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;

    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT = 2'd1;
    localparam logic [CFG_W-1:0]     TEX_SIZE_RESET = 9'd256;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    localparam int COORD_W = 32;
    localparam int TXC_W   = 16;
    localparam int CH_W    = 8;
    localparam int TEXEL_W = 3 * CH_W;
    localparam int FRAC_W  = 16;

    // scaled coordinate and its integer part
    localparam int SU_W = COORD_W + CFG_W + 1;
    localparam int N_W  = SU_W - FRAC_W;

    // modulo unit: digits per stage and pipeline depth
    localparam int WRAP_DIGITS     = 5;
    localparam int WRAP_DIG_STAGES = (N_W + WRAP_DIGITS - 1) / WRAP_DIGITS;
    localparam int WRAP_MAG_W      = WRAP_DIG_STAGES * WRAP_DIGITS;
    localparam int WRAP_LAT        = WRAP_DIG_STAGES + 2;

    localparam int TEX_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int TEX_AW    = (TEX_DEPTH > 1) ? $clog2(TEX_DEPTH) : 1;

    localparam int WGT_W = FRAC_W + 1;
    localparam int ROW_W = FRAC_W + CH_W;
    localparam int COL_W = WGT_W + ROW_W;
    localparam int SUM_W = COL_W + 1;

endpackage

// ===== design/wbts_smp_if.sv =====
// Input channel of the texture sampler: write and sample words.
// Depends on wbts_pkg.
interface wbts_smp_if;
    logic                               valid;
    logic                               ready;
    logic                               func;
    logic signed [wbts_pkg::TXC_W-1:0]   texel_x;
    logic signed [wbts_pkg::TXC_W-1:0]   texel_y;
    logic        [wbts_pkg::CH_W-1:0]    write_red;
    logic        [wbts_pkg::CH_W-1:0]    write_green;
    logic        [wbts_pkg::CH_W-1:0]    write_blue;
    logic signed [wbts_pkg::COORD_W-1:0] coord_u;
    logic signed [wbts_pkg::COORD_W-1:0] coord_v;
    logic                               bilinear;

    modport source (output valid, func, texel_x, texel_y, write_red, write_green,
                    write_blue, coord_u, coord_v, bilinear, input ready);
    modport sink   (input valid, func, texel_x, texel_y, write_red, write_green,
                    write_blue, coord_u, coord_v, bilinear, output ready);
endinterface

// ===== design/wbts_res_if.sv =====
// Output channel of the texture sampler: sampled color words.
// Depends on wbts_pkg.
interface wbts_res_if;
    logic                         valid;
    logic                         ready;
    logic [wbts_pkg::CH_W-1:0]    out_red;
    logic [wbts_pkg::CH_W-1:0]    out_green;
    logic [wbts_pkg::CH_W-1:0]    out_blue;

    modport source (output valid, out_red, out_green, out_blue, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface

// ===== design/wbts_ram.sv =====
// Generic RAM: one write port, one read port with registered read data.
// No dependencies.
module wbts_ram #(
    parameter  int WIDTH = 24,
    parameter  int DEPTH = 65536,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/wbts_wrap.sv =====
// Pipelined true modulo of a signed coordinate by the texture size.
// Depends on wbts_pkg; every register advances only on i_en.
module wbts_wrap (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [wbts_pkg::N_W-1:0]   i_n,
    input  logic        [wbts_pkg::CFG_W-1:0] i_size,
    output logic        [wbts_pkg::CFG_W-1:0] o_rem
);
    localparam int ST  = wbts_pkg::WRAP_DIG_STAGES;
    localparam int DG  = wbts_pkg::WRAP_DIGITS;
    localparam int MW  = wbts_pkg::WRAP_MAG_W;
    localparam int SW  = wbts_pkg::CFG_W;
    localparam int NW  = wbts_pkg::N_W;

    // restoring remainder over a few bits of the magnitude
    function automatic logic [SW:0] digit_step(input logic [SW:0]   rem,
                                               input logic [DG-1:0] bits,
                                               input logic [SW-1:0] size);
        logic [SW:0] r;
        r = rem;
        for (int b = DG - 1; b >= 0; b--) begin
            r = {r[SW-1:0], bits[b]};
            if (r >= {1'b0, size}) begin
                r = r - {1'b0, size};
            end
        end
        return r;
    endfunction

    logic          r_neg [0:ST];
    logic [MW-1:0] r_mag [0:ST-1];
    logic [SW:0]   r_rem [0:ST];
    logic [SW-1:0] r_out;
    logic [NW-1:0] w_abs;

    assign w_abs = i_n[NW-1] ? NW'(-i_n) : NW'(i_n);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg[0] <= i_n[NW-1];
            r_mag[0] <= MW'(w_abs);
            r_rem[0] <= '0;
        end
    end

    for (genvar s = 0; s < ST; s++) begin : g_digit
        logic [SW:0] n_rem;
        always_comb begin
            n_rem = digit_step(r_rem[s], r_mag[s][MW-1 -: DG], i_size);
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= n_rem;
                r_neg[s+1] <= r_neg[s];
            end
        end
        if (s < ST - 1) begin : g_mag
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_mag[s+1] <= r_mag[s] << DG;
                end
            end
        end
    end

    // negative input with nonzero remainder folds back from the top
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_neg[ST] && (r_rem[ST] != '0)) begin
                r_out <= SW'({1'b0, i_size} - r_rem[ST]);
            end else begin
                r_out <= SW'(r_rem[ST]);
            end
        end
    end

    assign o_rem = r_out;
endmodule

// ===== design/wrapped_bilinear_texture_sampler_top.sv =====
// Wrapped texture sampler: one word accepted per cycle while ready is high, writes and samples mixed freely.
// Each accepted sample word gives one result word; writes give none.
// Most of the depth is the coordinate modulo pipeline (8 stages); the four-copy texel store adds to it.
// Stalls on the output hold the whole pipe once the two-word output buffer is full.
// Reset clears all valid bits and sets both sizes to 256; the texel store is not cleared.
module wrapped_bilinear_texture_sampler_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [wbts_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [wbts_pkg::CFG_W-1:0]           i_cfg_data,
    wbts_smp_if.sink                             i_smp,
    wbts_res_if.source                           o_res
);
    localparam int SW  = wbts_pkg::CFG_W;
    localparam int FW  = wbts_pkg::FRAC_W;
    localparam int CW  = wbts_pkg::CH_W;
    localparam int TW  = wbts_pkg::TEXEL_W;
    localparam int SUW = wbts_pkg::SU_W;
    localparam int NW  = wbts_pkg::N_W;
    localparam int AW  = wbts_pkg::TEX_AW;
    localparam int WL  = wbts_pkg::WRAP_LAT;
    localparam int GW  = wbts_pkg::WGT_W;
    localparam int RW  = wbts_pkg::ROW_W;
    localparam int LW  = wbts_pkg::COL_W;
    localparam int MW  = wbts_pkg::SUM_W;

    typedef struct packed {
        logic          func;
        logic [FW-1:0] fx;
        logic [FW-1:0] fy;
        logic [TW-1:0] rgb;
    } t_side;

    function automatic logic [AW-1:0] tex_addr(input logic [SW-1:0] x,
                                               input logic [SW-1:0] y);
        return AW'(int'(y) * wbts_pkg::MAX_WIDTH + int'(x));
    endfunction

    // configuration
    logic [SW-1:0] r_tex_w, r_tex_h, w_eff, h_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_w <= wbts_pkg::TEX_SIZE_RESET;
            r_tex_h <= wbts_pkg::TEX_SIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                wbts_pkg::CFG_TEX_WIDTH:  r_tex_w <= i_cfg_data;
                wbts_pkg::CFG_TEX_HEIGHT: r_tex_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_tex_w == '0) begin
            w_eff = SW'(1);
        end else if (int'(r_tex_w) > wbts_pkg::MAX_WIDTH) begin
            w_eff = SW'(wbts_pkg::MAX_WIDTH);
        end else begin
            w_eff = r_tex_w;
        end
        if (r_tex_h == '0) begin
            h_eff = SW'(1);
        end else if (int'(r_tex_h) > wbts_pkg::MAX_HEIGHT) begin
            h_eff = SW'(wbts_pkg::MAX_HEIGHT);
        end else begin
            h_eff = r_tex_h;
        end
    end

    logic r_skid_v, w_en;
    assign w_en = !r_skid_v;
    assign i_smp.ready = w_en;

    // stage 1: input word
    logic                         r1_v, r1_func, r1_bil;
    logic signed [wbts_pkg::TXC_W-1:0]   r1_x, r1_y;
    logic        [TW-1:0]                r1_rgb;
    logic signed [wbts_pkg::COORD_W-1:0] r1_u, r1_v_c;

    // stage 2: scaled coordinates
    logic                    r2_v, r2_func, r2_bil;
    logic signed [wbts_pkg::TXC_W-1:0] r2_x, r2_y;
    logic        [TW-1:0]    r2_rgb;
    logic signed [SUW-1:0]   r2_su, r2_sv;

    // stage 3: integer coordinates and fractions
    logic                  r3_v;
    logic signed [NW-1:0]  r3_nx, r3_ny, n3_nx, n3_ny;
    t_side                 r3_side, n3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_smp.valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_comb begin
        n3_side.func = r2_func;
        n3_side.rgb  = r2_rgb;
        if (r2_func == wbts_pkg::FUNC_WRITE) begin
            n3_nx      = NW'(r2_x);
            n3_ny      = NW'(r2_y);
            n3_side.fx = '0;
            n3_side.fy = '0;
        end else if (r2_bil) begin
            n3_nx      = NW'(r2_su >>> FW);
            n3_ny      = NW'(r2_sv >>> FW);
            n3_side.fx = r2_su[FW-1:0];
            n3_side.fy = r2_sv[FW-1:0];
        end else begin
            // round half away from zero: bias one less below zero, then floor
            n3_nx      = NW'((r2_su + SUW'(2 ** (FW - 1)) - SUW'(r2_su[SUW-1])) >>> FW);
            n3_ny      = NW'((r2_sv + SUW'(2 ** (FW - 1)) - SUW'(r2_sv[SUW-1])) >>> FW);
            n3_side.fx = '0;
            n3_side.fy = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_func <= i_smp.func;
            r1_bil  <= i_smp.bilinear;
            r1_x    <= i_smp.texel_x;
            r1_y    <= i_smp.texel_y;
            r1_rgb  <= {i_smp.write_blue, i_smp.write_green, i_smp.write_red};
            r1_u    <= i_smp.coord_u;
            r1_v_c  <= i_smp.coord_v;
            r2_func <= r1_func;
            r2_bil  <= r1_bil;
            r2_x    <= r1_x;
            r2_y    <= r1_y;
            r2_rgb  <= r1_rgb;
            r2_su   <= SUW'(r1_u * $signed({1'b0, w_eff}));
            r2_sv   <= SUW'(r1_v_c * $signed({1'b0, h_eff}));
            r3_nx   <= n3_nx;
            r3_ny   <= n3_ny;
            r3_side <= n3_side;
        end
    end

    // coordinate wrap, side data travels alongside
    logic [SW-1:0] w_wx, w_wy;

    wbts_wrap u_wrap_x (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_n    (r3_nx),
        .i_size (w_eff),
        .o_rem  (w_wx)
    );

    wbts_wrap u_wrap_y (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_n    (r3_ny),
        .i_size (h_eff),
        .o_rem  (w_wy)
    );

    logic  r_dl_v    [0:WL-1];
    t_side r_dl_side [0:WL-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WL; k++) begin
                r_dl_v[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_dl_v[0] <= r3_v;
            for (int k = 1; k < WL; k++) begin
                r_dl_v[k] <= r_dl_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dl_side[0] <= r3_side;
            for (int k = 1; k < WL; k++) begin
                r_dl_side[k] <= r_dl_side[k-1];
            end
        end
    end

    // stage A: neighbor addresses
    t_side         w_tail;
    logic [SW:0]   w_xp, w_yp;
    logic [SW-1:0] w_x1, w_y1;
    logic [AW-1:0] rA_addr [0:3];
    logic          rA_wr, rA_smp;
    logic [TW-1:0] rA_wdata;
    logic [FW-1:0] rA_fx, rA_fy;

    assign w_tail = r_dl_side[WL-1];
    assign w_xp   = {1'b0, w_wx} + 1'b1;
    assign w_yp   = {1'b0, w_wy} + 1'b1;

    always_comb begin
        w_x1 = w_wx;
        w_y1 = w_wy;
        if (w_tail.fx != '0) begin
            w_x1 = (w_xp == {1'b0, w_eff}) ? '0 : SW'(w_xp);
        end
        if (w_tail.fy != '0) begin
            w_y1 = (w_yp == {1'b0, h_eff}) ? '0 : SW'(w_yp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rA_wr  <= 1'b0;
            rA_smp <= 1'b0;
        end else if (w_en) begin
            rA_wr  <= r_dl_v[WL-1] && (w_tail.func == wbts_pkg::FUNC_WRITE);
            rA_smp <= r_dl_v[WL-1] && (w_tail.func == wbts_pkg::FUNC_SAMPLE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rA_addr[0] <= tex_addr(w_wx, w_wy);
            rA_addr[1] <= tex_addr(w_x1, w_wy);
            rA_addr[2] <= tex_addr(w_wx, w_y1);
            rA_addr[3] <= tex_addr(w_x1, w_y1);
            rA_wdata   <= w_tail.rgb;
            rA_fx      <= w_tail.fx;
            rA_fy      <= w_tail.fy;
        end
    end

    // stage B: four copies of the texture, written together, each read at its neighbor
    logic [TW-1:0] w_rd [0:3];

    for (genvar k = 0; k < 4; k++) begin : g_store
        wbts_ram #(
            .WIDTH (TW),
            .DEPTH (wbts_pkg::TEX_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_en && rA_wr),
            .i_waddr (rA_addr[0]),
            .i_wdata (rA_wdata),
            .i_re    (w_en),
            .i_raddr (rA_addr[k]),
            .o_rdata (w_rd[k])
        );
    end

    logic          rB_v;
    logic [FW-1:0] rB_fx, rB_fy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rB_v <= 1'b0;
        end else if (w_en) begin
            rB_v <= rA_smp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rB_fx <= rA_fx;
            rB_fy <= rA_fy;
        end
    end

    // stage C: horizontal blend of both rows
    logic [GW-1:0] w_wx0, w_wx1;
    logic [RW-1:0] n_rt [0:2];
    logic [RW-1:0] n_rb [0:2];
    logic [RW-1:0] rC_rt [0:2];
    logic [RW-1:0] rC_rb [0:2];
    logic [GW-1:0] rC_wy0, rC_wy1;
    logic          rC_v;

    assign w_wx0 = GW'(2 ** FW) - GW'(rB_fx);
    assign w_wx1 = GW'(rB_fx);

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_rt[c] = RW'(w_wx0 * GW'(w_rd[0][c*CW +: CW]) + w_wx1 * GW'(w_rd[1][c*CW +: CW]));
            n_rb[c] = RW'(w_wx0 * GW'(w_rd[2][c*CW +: CW]) + w_wx1 * GW'(w_rd[3][c*CW +: CW]));
        end
    end

    // stage D: vertical weights
    logic [LW-1:0] rD_p0 [0:2];
    logic [LW-1:0] rD_p1 [0:2];
    logic          rD_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rC_v <= 1'b0;
            rD_v <= 1'b0;
        end else if (w_en) begin
            rC_v <= rB_v;
            rD_v <= rC_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rC_wy0 <= GW'(2 ** FW) - GW'(rB_fy);
            rC_wy1 <= GW'(rB_fy);
            for (int c = 0; c < 3; c++) begin
                rC_rt[c] <= n_rt[c];
                rC_rb[c] <= n_rb[c];
                rD_p0[c] <= LW'(rC_wy0 * LW'(rC_rt[c]));
                rD_p1[c] <= LW'(rC_wy1 * LW'(rC_rb[c]));
            end
        end
    end

    // sum, round, saturate
    logic [MW-1:0] w_sum [0:2];
    logic [TW-1:0] n_rgb;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_sum[c] = MW'(rD_p0[c]) + MW'(rD_p1[c]) + MW'(2 ** (2 * FW - 1));
            if (w_sum[c][MW-1:2*FW] > (MW - 2 * FW)'(2 ** CW - 1)) begin
                n_rgb[c*CW +: CW] = '1;
            end else begin
                n_rgb[c*CW +: CW] = w_sum[c][2*FW +: CW];
            end
        end
    end

    // output register with one skid word behind it
    logic          r_o_v;
    logic [TW-1:0] r_o_rgb, r_skid_rgb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v    <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (o_res.ready) begin
                r_skid_v <= 1'b0;
            end
        end else if (rD_v) begin
            if (r_o_v && !o_res.ready) begin
                r_skid_v <= 1'b1;
            end else begin
                r_o_v <= 1'b1;
            end
        end else if (o_res.ready) begin
            r_o_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (o_res.ready) begin
                r_o_rgb <= r_skid_rgb;
            end
        end else if (rD_v) begin
            if (r_o_v && !o_res.ready) begin
                r_skid_rgb <= n_rgb;
            end else begin
                r_o_rgb <= n_rgb;
            end
        end
    end

    assign o_res.valid     = r_o_v;
    assign o_res.out_red   = r_o_rgb[CW-1:0];
    assign o_res.out_green = r_o_rgb[2*CW-1:CW];
    assign o_res.out_blue  = r_o_rgb[3*CW-1:2*CW];
endmodule

// ===== design/wbts_checker.sv =====
// Port-level checks of the texture sampler, bound to the top level.
// Depends on wbts_pkg and the macro header.
`include "wrapped_bilinear_texture_sampler_top_macros.svh"

module wbts_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [wbts_pkg::TEXEL_W-1:0]  i_out_data
);
    `WBTS_ASSERT_RST(a_rst_no_word, i_clk, i_rst_n, !i_out_valid)
    `WBTS_ASSERT_NXT(a_hold_valid, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `WBTS_ASSERT_NXT(a_hold_word, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_data))
    // input backs up only after the output word sat untaken
    `WBTS_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, !i_in_ready, $past(i_out_valid && !i_out_ready))
endmodule

bind wrapped_bilinear_texture_sampler_top wbts_checker u_wbts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_smp.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  ({o_res.out_blue, o_res.out_green, o_res.out_red})
);
